[rtl/core/lcdw_pkg.sv]
package lcdw_pkg;

  typedef enum logic [2:0] {
    PH_POWER,
    PH_SETUP,
    PH_PULSE,
    PH_HOLD,
    PH_IDLE
  } phase_t;

  typedef logic [2:0] cfg_index_t;

  localparam cfg_index_t CFG_POWER_ON_WAIT    = 3'd0;
  localparam cfg_index_t CFG_SETUP_WAIT       = 3'd1;
  localparam cfg_index_t CFG_PULSE_WIDTH      = 3'd2;
  localparam cfg_index_t CFG_SHORT_WAIT       = 3'd3;
  localparam cfg_index_t CFG_LONG_WAIT        = 3'd4;
  localparam cfg_index_t CFG_CLEAR_EXTRA_WAIT = 3'd5;

  localparam logic [15:0] RST_POWER_ON_WAIT    = 16'd15000;
  localparam logic [15:0] RST_SETUP_WAIT       = 16'd4200;
  localparam logic [7:0]  RST_PULSE_WIDTH      = 8'd2;
  localparam logic [15:0] RST_SHORT_WAIT       = 16'd100;
  localparam logic [15:0] RST_LONG_WAIT        = 16'd2000;
  localparam logic [15:0] RST_CLEAR_EXTRA_WAIT = 16'd2000;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_CMD    = 2'd1;
  localparam logic [1:0] MODE_CHAR   = 2'd2;
  localparam logic [1:0] MODE_CURSOR = 2'd3;

  localparam logic [2:0]  INIT_DONE       = 3'd4;
  localparam logic [2:0]  INIT_CLEAR_STEP = 3'd2;
  localparam logic [7:0]  LINE1_BASE      = 8'h40;
  localparam logic [7:0]  SET_ADDR_BIT    = 8'h80;
  localparam logic [7:0]  CMD_CLEAR       = 8'h01;
  localparam logic [7:0]  CMD_CURSOR_HOME = 8'h03;
  localparam logic [16:0] WAIT_MAX        = 17'h1FFFF;

  localparam logic [7:0] INIT_CMDS [4] = '{8'h38, 8'h0E, 8'h01, 8'h06};

  typedef struct packed {
    logic [15:0] power_on_wait;
    logic [15:0] setup_wait;
    logic [7:0]  pulse_width;
    logic [15:0] short_wait;
    logic [15:0] long_wait;
    logic [15:0] clear_extra_wait;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte_value;
    logic [5:0] column;
    logic [1:0] row;
  } item_t;

  typedef struct packed {
    logic [7:0] data_bus;
    logic       reg_select;
    logic       enable_line;
    logic       ready_res;
    logic       refused;
  } result_t;

  typedef struct packed {
    phase_t      phase;
    logic [16:0] wait_count;
    logic [2:0]  init_step;
    logic [7:0]  bus_latch;
    logic        rs_latch;
    logic        enable_latch;
  } state_t;

  function automatic logic [16:0] phase_target(state_t s, cfg_t c);
    logic [16:0] t;
    t = '0;
    unique case (s.phase)
      PH_POWER: t = {1'b0, c.power_on_wait};
      PH_SETUP: t = {1'b0, c.setup_wait};
      PH_PULSE: t = (c.pulse_width == 8'd0) ? 17'd1 : {9'd0, c.pulse_width};
      PH_HOLD: begin
        if (!s.rs_latch && s.bus_latch >= CMD_CLEAR && s.bus_latch <= CMD_CURSOR_HOME) begin
          t = {1'b0, c.long_wait};
        end else begin
          t = {1'b0, c.short_wait};
        end
        if (s.init_step == INIT_CLEAR_STEP) begin
          t = t + {1'b0, c.clear_extra_wait};
        end
      end
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic state_t start_write(state_t s, logic [7:0] b, logic rs);
    state_t r;
    r = s;
    r.bus_latch    = b;
    r.rs_latch     = rs;
    r.enable_latch = 1'b1;
    r.phase        = PH_PULSE;
    r.wait_count   = '0;
    return r;
  endfunction

  function automatic state_t end_phase(state_t s);
    state_t r;
    logic [2:0] step;
    r = s;
    step = s.init_step + 3'd1;
    unique case (s.phase)
      PH_POWER: begin
        r.phase      = PH_SETUP;
        r.wait_count = '0;
      end
      PH_SETUP: begin
        r.init_step = '0;
        r = start_write(r, INIT_CMDS[0], 1'b0);
      end
      PH_PULSE: begin
        r.enable_latch = 1'b0;
        r.phase        = PH_HOLD;
        r.wait_count   = '0;
      end
      PH_HOLD: begin
        r.rs_latch   = 1'b0;
        r.wait_count = '0;
        r.phase      = PH_IDLE;
        if (s.init_step < INIT_DONE) begin
          r.init_step = step;
          if (step < INIT_DONE) begin
            r = start_write(r, INIT_CMDS[step[1:0]], 1'b0);
          end
        end
      end
      default: begin
        r.phase      = PH_IDLE;
        r.wait_count = '0;
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/core/lcdw_cfg.sv]
module lcdw_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  lcdw_pkg::cfg_index_t cfg_index,
  input  logic [15:0]         cfg_data,
  output lcdw_pkg::cfg_t      cfg
);
  import lcdw_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_on_wait    <= RST_POWER_ON_WAIT;
      cfg.setup_wait       <= RST_SETUP_WAIT;
      cfg.pulse_width      <= RST_PULSE_WIDTH;
      cfg.short_wait       <= RST_SHORT_WAIT;
      cfg.long_wait        <= RST_LONG_WAIT;
      cfg.clear_extra_wait <= RST_CLEAR_EXTRA_WAIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_POWER_ON_WAIT:    cfg.power_on_wait    <= cfg_data;
        CFG_SETUP_WAIT:       cfg.setup_wait       <= cfg_data;
        CFG_PULSE_WIDTH:      cfg.pulse_width      <= cfg_data[7:0];
        CFG_SHORT_WAIT:       cfg.short_wait       <= cfg_data;
        CFG_LONG_WAIT:        cfg.long_wait        <= cfg_data;
        CFG_CLEAR_EXTRA_WAIT: cfg.clear_extra_wait <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/lcdw_seq.sv]
module lcdw_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              process,
  input  lcdw_pkg::item_t   item,
  input  lcdw_pkg::cfg_t    cfg,
  output lcdw_pkg::result_t result
);
  import lcdw_pkg::*;

  state_t state;
  state_t state_next;
  state_t settled;
  state_t stepped;
  state_t advanced;
  logic   ready;

  // End every phase that is due; two passes cover the longest chain of zero waits.
  function automatic state_t catch_up(state_t s, cfg_t c);
    state_t r;
    r = s;
    for (int i = 0; i < 2; i++) begin
      if (r.phase != PH_IDLE && r.wait_count >= phase_target(r, c)) begin
        r = end_phase(r);
      end
    end
    return r;
  endfunction

  // Catch up on any phase ends that are due under the current timing.
  always_comb begin
    settled = catch_up(state, cfg);
  end

  always_comb begin
    logic [7:0] base;
    base    = (item.row == 2'd1) ? LINE1_BASE : 8'h00;
    ready   = (settled.phase == PH_IDLE);
    stepped = settled;
    if (ready) begin
      case (item.mode)
        MODE_CMD:    stepped = start_write(settled, item.byte_value, 1'b0);
        MODE_CHAR:   stepped = start_write(settled, item.byte_value, 1'b1);
        MODE_CURSOR: stepped = start_write(settled,
                                           SET_ADDR_BIT | (base + {2'b00, item.column}), 1'b0);
        default: ;
      endcase
    end
  end

  // Count the tick, then close the phases it finishes; hold the state between ticks.
  always_comb begin
    advanced = stepped;
    if (stepped.phase != PH_IDLE && stepped.wait_count != WAIT_MAX) begin
      advanced.wait_count = stepped.wait_count + 17'd1;
    end
    state_next = state;
    if (process) begin
      state_next = catch_up(advanced, cfg);
    end
  end

  always_comb begin
    result.data_bus    = stepped.bus_latch;
    result.reg_select  = stepped.rs_latch;
    result.enable_line = stepped.enable_latch;
    result.ready_res   = ready;
    result.refused     = (item.mode != MODE_IDLE) && !ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= PH_POWER;
      state.wait_count   <= '0;
      state.init_step    <= '0;
      state.bus_latch    <= '0;
      state.rs_latch     <= 1'b0;
      state.enable_latch <= 1'b0;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/char_lcd_parallel_writer_top.sv]
// Character LCD write sequencer for an 8-bit parallel bus (RS, E, D7..D0; RW tied low).
//
// Input channel (in_valid / in_stall): one transaction per 1 us tick of the timing base.
//   mode 0 is an idle tick, 1 sends byte_value as a command, 2 sends it as a character,
//   3 moves the cursor to (row, column); row 1 picks the second line, any other row the
//   first. A request that comes during power-up, the setup wait, a write or its hold
//   is dropped and flagged in refused.
// Output channel (out_valid / out_stall): one transaction per input tick carrying the
//   bus levels for that tick plus ready_res and refused.
// Config channel (cfg_valid / cfg_ready): cfg_ready is always high; cfg_index selects
//   one of the six timing registers, unknown indexes are ignored. Write only while no
//   tick is in flight.
// Path: a tick accepted into the input register is processed into the result register
//   and shows on the output from then on. Throughput: one tick per cycle while out_stall
//   is low, set by the single pass through the phase sequencer between the two registers.
// Reset: timing registers take their defaults and the sequencer starts the power-up
//   wait, then the setup wait and the four init commands, all counted in input ticks.
// Stall: while out_stall holds a result, one more tick waits in the input register,
//   then in_stall rises until the output drains. Time only advances with ticks.
module char_lcd_parallel_writer_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           mode,
  input  logic [7:0]           byte_value,
  input  logic [5:0]           column,
  input  logic [1:0]           row,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           data_bus,
  output logic                 reg_select,
  output logic                 enable_line,
  output logic                 ready_res,
  output logic                 refused,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  lcdw_pkg::cfg_index_t cfg_index,
  input  logic [15:0]          cfg_data
);
  import lcdw_pkg::*;

  cfg_t    cfg;
  item_t   in_q;
  logic    in_full;
  logic    process;
  logic    in_accept;
  result_t result;

  assign cfg_ready = 1'b1;

  // Process the held tick whenever the output register is free or being drained.
  assign process   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !process;
  assign in_accept = in_valid && !in_stall;

  lcdw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lcdw_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .process (process),
    .item    (in_q),
    .cfg     (cfg),
    .result  (result)
  );

  // Input register: hold the tick until the sequencer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (process) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_q.mode       <= mode;
      in_q.byte_value <= byte_value;
      in_q.column     <= column;
      in_q.row        <= row;
    end
  end

  // Result register: load on process, drop once the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      data_bus    <= result.data_bus;
      reg_select  <= result.reg_select;
      enable_line <= result.enable_line;
      ready_res   <= result.ready_res;
      refused     <= result.refused;
    end
  end

  // A tick is either taken while idle or refused, never both.
  a_ready_refused: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(ready_res && refused))
    else $error("ready_res and refused both set");

  // A processed tick always lands in the result register.
  a_process_loads: assert property (@(posedge clk) disable iff (rst)
    process |=> out_valid)
    else $error("processed tick did not reach output");

  // A stalled, full output must back-pressure a held input tick.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && in_full) |-> in_stall)
    else $error("input not stalled while output blocked");

  // An empty input register never stalls the sender.
  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !in_full |-> !in_stall)
    else $error("stall raised with empty input register");

endmodule

[test/char_lcd_parallel_writer_top_tb.sv]
`timescale 1ns / 100ps

module char_lcd_parallel_writer_top_tb;
  import lcdw_pkg::*;

  // Row code 1 selects the second display line; every other row falls back to the first.
  localparam logic [1:0] SECOND_ROW = 2'd1;
  // Indexes past the six timing registers; writes to them must leave timing untouched.
  localparam cfg_index_t CFG_SPARE_6 = 3'd6;
  localparam cfg_index_t CFG_SPARE_7 = 3'd7;

  localparam int RAND_PHASES     = 8;
  localparam int TICKS_PER_PHASE = 138;
  localparam int SETTLE_CYCLES   = 8;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PRINT_LIMIT     = 40;

  // Ports
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] mode = MODE_IDLE;
  logic [7:0] byte_value = 8'h00;
  logic [5:0] column = 6'd0;
  logic [1:0] row = 2'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] data_bus;
  logic       reg_select;
  logic       enable_line;
  logic       ready_res;
  logic       refused;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index = CFG_POWER_ON_WAIT;
  logic [15:0] cfg_data = 16'h0000;

  // Idle profile of both sides, changed per phase
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  int unsigned cycle_count = 0;
  int mismatch_count = 0;
  int results_seen = 0;

  // Bus levels the LCD should show, one entry per accepted tick
  result_t expected_levels [$];

  // Shadow of the sequencer: timing registers and latches
  cfg_t        timing;
  phase_t      lcd_phase;
  logic [16:0] tick_count;
  logic [2:0]  init_idx;
  logic [7:0]  bus_latched;
  logic        rs_latched;
  logic        e_latched;

  // One row of the directed sequence: a register write or a tick, with an optional
  // hand-written expectation.
  typedef struct {
    bit          is_cfg;
    cfg_index_t  reg_idx;
    logic [15:0] reg_val;
    item_t       tick;
    bit          fixed;
    result_t     want;
  } stim_row_t;

  char_lcd_parallel_writer_top DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sequencer shadow
  // ---------------------------------------------------------------------------

  // Ticks the current phase must last before it ends.
  function automatic logic [16:0] phase_limit();
    logic [16:0] lim;
    lim = '0;
    case (lcd_phase)
      PH_POWER: lim = {1'b0, timing.power_on_wait};
      PH_SETUP: lim = {1'b0, timing.setup_wait};
      // a pulse width of zero still gives a one-tick strobe
      PH_PULSE: lim = (timing.pulse_width == 8'd0) ? 17'd1 : {9'd0, timing.pulse_width};
      PH_HOLD: begin
        // clear and home commands get the long hold; a character never does
        if (!rs_latched && bus_latched >= CMD_CLEAR && bus_latched <= CMD_CURSOR_HOME) begin
          lim = {1'b0, timing.long_wait};
        end else begin
          lim = {1'b0, timing.short_wait};
        end
        // the clear sent during init gets its extra settle time on top
        if (init_idx == INIT_CLEAR_STEP) begin
          lim = lim + {1'b0, timing.clear_extra_wait};
        end
      end
      default: lim = '0;
    endcase
    return lim;
  endfunction

  function automatic void launch_write(logic [7:0] b, logic rs);
    bus_latched = b;
    rs_latched  = rs;
    e_latched   = 1'b1;
    lcd_phase   = PH_PULSE;
    tick_count  = '0;
  endfunction

  function automatic void close_phase();
    case (lcd_phase)
      PH_POWER: begin
        lcd_phase  = PH_SETUP;
        tick_count = '0;
      end
      PH_SETUP: begin
        init_idx = '0;
        launch_write(INIT_CMDS[0], 1'b0);
      end
      PH_PULSE: begin
        e_latched  = 1'b0;
        lcd_phase  = PH_HOLD;
        tick_count = '0;
      end
      PH_HOLD: begin
        // RS drops only once the hold is over
        rs_latched = 1'b0;
        tick_count = '0;
        lcd_phase  = PH_IDLE;
        if (init_idx < INIT_DONE) begin
          init_idx = init_idx + 3'd1;
          if (init_idx < INIT_DONE) begin
            launch_write(INIT_CMDS[init_idx[1:0]], 1'b0);
          end
        end
      end
      default: begin
        lcd_phase  = PH_IDLE;
        tick_count = '0;
      end
    endcase
  endfunction

  // Close every phase whose time is up; zero waits fall through without a tick.
  function automatic void catch_up();
    for (int g = 0; g < 16; g++) begin
      if (lcd_phase == PH_IDLE || tick_count < phase_limit()) return;
      close_phase();
    end
  endfunction

  // Advance the shadow by one tick and return the levels the block must show for it.
  function automatic result_t lcd_tick(item_t t);
    result_t    r;
    logic       idle_now;
    logic [7:0] line_base;
    catch_up();
    idle_now    = (lcd_phase == PH_IDLE);
    r.ready_res = idle_now;
    r.refused   = (t.mode != MODE_IDLE) && !idle_now;
    if (idle_now) begin
      case (t.mode)
        MODE_CMD:  launch_write(t.byte_value, 1'b0);
        MODE_CHAR: launch_write(t.byte_value, 1'b1);
        MODE_CURSOR: begin
          line_base = (t.row == SECOND_ROW) ? LINE1_BASE : 8'h00;
          launch_write(SET_ADDR_BIT | (line_base + {2'b00, t.column}), 1'b0);
        end
        default: ;
      endcase
    end
    r.data_bus    = bus_latched;
    r.reg_select  = rs_latched;
    r.enable_line = e_latched;
    if (lcd_phase != PH_IDLE && tick_count < WAIT_MAX) tick_count = tick_count + 17'd1;
    catch_up();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic stim_row_t tick_row(logic [1:0] m, logic [7:0] b, logic [5:0] c,
                                         logic [1:0] r);
    stim_row_t s;
    s.is_cfg  = 1'b0;
    s.reg_idx = CFG_POWER_ON_WAIT;
    s.reg_val = '0;
    s.tick    = '{mode: m, byte_value: b, column: c, row: r};
    s.fixed   = 1'b0;
    s.want    = '0;
    return s;
  endfunction

  function automatic stim_row_t fixed_row(logic [1:0] m, logic [7:0] b, logic [5:0] c,
                                          logic [1:0] r, result_t want);
    stim_row_t s;
    s       = tick_row(m, b, c, r);
    s.fixed = 1'b1;
    s.want  = want;
    return s;
  endfunction

  function automatic stim_row_t cfg_row(cfg_index_t idx, logic [15:0] val);
    stim_row_t s;
    s         = tick_row(MODE_IDLE, 8'h00, 6'd0, 2'd0);
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  // Mostly well-formed traffic: requests when the sequencer is free, idle ticks while
  // it is busy, with a share of requests thrown at a busy block as noise.
  function automatic item_t random_tick();
    item_t t;
    int    draw;
    draw         = $urandom_range(99);
    t.byte_value = 8'($urandom);
    t.column     = 6'($urandom);
    t.row        = 2'($urandom);
    if ((lcd_phase == PH_IDLE) ? (draw < 85) : (draw < 15)) begin
      t.mode = 2'($urandom_range(1, 3));
    end else begin
      t.mode = MODE_IDLE;
    end
    // steer some commands onto clear, home and their neighbors
    if (t.mode == MODE_CMD && $urandom_range(3) == 0) t.byte_value = 8'($urandom_range(0, 4));
    return t;
  endfunction

  task automatic note_mismatch(string what);
    if (mismatch_count < PRINT_LIMIT) $display("[%0t] result %0d: %s", $time, results_seen, what);
    mismatch_count++;
  endtask

  // Send one tick transaction, with random sender gaps ahead of it.
  task automatic send_tick(item_t t, bit fixed, result_t want);
    result_t predicted;
    predicted = lcd_tick(t);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    mode       <= t.mode;
    byte_value <= t.byte_value;
    column     <= t.column;
    row        <= t.row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_levels.push_back(fixed ? want : predicted);
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // mirror the write; unused indexes change nothing
    case (idx)
      CFG_POWER_ON_WAIT:    timing.power_on_wait    = val;
      CFG_SETUP_WAIT:       timing.setup_wait       = val;
      CFG_PULSE_WIDTH:      timing.pulse_width      = val[7:0];
      CFG_SHORT_WAIT:       timing.short_wait       = val;
      CFG_LONG_WAIT:        timing.long_wait        = val;
      CFG_CLEAR_EXTRA_WAIT: timing.clear_extra_wait = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, driven on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  // Check each result transaction against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_levels.size() == 0) begin
        note_mismatch($sformatf("unexpected result, bus %h", data_bus));
      end else begin
        want = expected_levels.pop_front();
        if (data_bus !== want.data_bus)
          note_mismatch($sformatf("data_bus %h, want %h", data_bus, want.data_bus));
        if (reg_select !== want.reg_select)
          note_mismatch($sformatf("reg_select %b, want %b", reg_select, want.reg_select));
        if (enable_line !== want.enable_line)
          note_mismatch($sformatf("enable_line %b, want %b", enable_line, want.enable_line));
        if (ready_res !== want.ready_res)
          note_mismatch($sformatf("ready_res %b, want %b", ready_res, want.ready_res));
        if (refused !== want.refused)
          note_mismatch($sformatf("refused %b, want %b", refused, want.refused));
      end
      results_seen++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** char_lcd_parallel_writer_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t rows [$];
    cfg_t      timing_sets [4];
    int        send_pct [4];
    int        stall_pct [4];
    cfg_t      pick;
    result_t   no_check;

    no_check  = '0;
    send_pct  = '{0, 46, 0, 20};
    stall_pct = '{0, 0, 46, 20};

    // Timing sets for the random phases; power and setup values only matter after
    // reset, so here they just push the register extremes.
    timing_sets[0] = '{power_on_wait: 16'd65535, setup_wait: 16'd0, pulse_width: 8'd1,
                       short_wait: 16'd0, long_wait: 16'd0, clear_extra_wait: 16'd65535};
    timing_sets[1] = '{power_on_wait: 16'd0, setup_wait: 16'd65535, pulse_width: 8'd255,
                       short_wait: 16'd3, long_wait: 16'd40, clear_extra_wait: 16'd0};
    timing_sets[2] = '{power_on_wait: 16'd100, setup_wait: 16'd7, pulse_width: 8'd0,
                       short_wait: 16'd1, long_wait: 16'd6, clear_extra_wait: 16'd9};
    timing_sets[3] = '{power_on_wait: 16'd1, setup_wait: 16'd1, pulse_width: 8'd4,
                       short_wait: 16'd12, long_wait: 16'd90, clear_extra_wait: 16'd1};

    // Shadow reset state
    timing = '{power_on_wait: RST_POWER_ON_WAIT, setup_wait: RST_SETUP_WAIT,
               pulse_width: RST_PULSE_WIDTH, short_wait: RST_SHORT_WAIT,
               long_wait: RST_LONG_WAIT, clear_extra_wait: RST_CLEAR_EXTRA_WAIT};
    lcd_phase   = PH_POWER;
    tick_count  = '0;
    init_idx    = '0;
    bus_latched = 8'h00;
    rs_latched  = 1'b0;
    e_latched   = 1'b0;

    // Directed part. Short timing first so init finishes in nine ticks: three of
    // power-up, then one strobe tick per init command plus the clear's two-tick hold.
    rows.push_back(cfg_row(CFG_POWER_ON_WAIT, 16'd3));
    rows.push_back(cfg_row(CFG_SETUP_WAIT, 16'd0));
    rows.push_back(cfg_row(CFG_PULSE_WIDTH, 16'd1));
    rows.push_back(cfg_row(CFG_SHORT_WAIT, 16'd0));
    rows.push_back(cfg_row(CFG_LONG_WAIT, 16'd1));
    rows.push_back(cfg_row(CFG_CLEAR_EXTRA_WAIT, 16'd1));
    rows.push_back(cfg_row(CFG_SPARE_6, 16'hFFFF));
    rows.push_back(cfg_row(CFG_SPARE_7, 16'h0000));
    // power-up: lines all low, requests refused
    rows.push_back(fixed_row(MODE_CMD, 8'h5A, 6'd0, 2'd0, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1}));
    rows.push_back(fixed_row(MODE_IDLE, 8'h00, 6'd0, 2'd0, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}));
    rows.push_back(fixed_row(MODE_CURSOR, 8'h00, 6'd63, 2'd3,
                             '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1}));
    // init sequence, with requests thrown at it
    rows.push_back(tick_row(MODE_IDLE, 8'h00, 6'd0, 2'd0));
    rows.push_back(tick_row(MODE_CHAR, 8'h41, 6'd0, 2'd0));
    rows.push_back(tick_row(MODE_IDLE, 8'h00, 6'd0, 2'd0));
    rows.push_back(tick_row(MODE_CMD, 8'hAA, 6'd0, 2'd0));
    rows.push_back(tick_row(MODE_IDLE, 8'h00, 6'd0, 2'd0));
    rows.push_back(tick_row(MODE_IDLE, 8'h00, 6'd0, 2'd0));
    // ready now: the accepting tick already shows the new byte with E high
    rows.push_back(fixed_row(MODE_CMD, 8'hFF, 6'd0, 2'd0, '{8'hFF, 1'b0, 1'b1, 1'b1, 1'b0}));
    rows.push_back(fixed_row(MODE_CHAR, 8'h00, 6'd0, 2'd0, '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0}));
    rows.push_back(tick_row(MODE_IDLE, 8'h00, 6'd0, 2'd0));
    rows.push_back(fixed_row(MODE_CURSOR, 8'h00, 6'd63, SECOND_ROW,
                             '{8'hFF, 1'b0, 1'b1, 1'b1, 1'b0}));
    rows.push_back(tick_row(MODE_CURSOR, 8'h00, 6'h2A, 2'd2));
    // clear with its long hold, a request refused while busy, then home commands
    rows.push_back(tick_row(MODE_CMD, CMD_CLEAR, 6'd0, 2'd0));
    rows.push_back(tick_row(MODE_CHAR, 8'h41, 6'd0, 2'd0));
    rows.push_back(tick_row(MODE_CMD, 8'h02, 6'd0, 2'd0));
    rows.push_back(tick_row(MODE_IDLE, 8'h00, 6'd0, 2'd0));
    rows.push_back(tick_row(MODE_CMD, CMD_CURSOR_HOME, 6'd0, 2'd0));
    rows.push_back(tick_row(MODE_CMD, 8'h04, 6'd0, 2'd0));
    rows.push_back(tick_row(MODE_CMD, 8'h00, 6'd0, 2'd0));
    // zero pulse width (upper data bits ignored) and the longest holds
    rows.push_back(cfg_row(CFG_PULSE_WIDTH, 16'hA500));
    rows.push_back(cfg_row(CFG_LONG_WAIT, 16'hFFFF));
    rows.push_back(cfg_row(CFG_SHORT_WAIT, 16'hFFFF));
    rows.push_back(tick_row(MODE_CMD, CMD_CLEAR, 6'd0, 2'd0));
    rows.push_back(tick_row(MODE_IDLE, 8'h00, 6'd0, 2'd0));
    rows.push_back(tick_row(MODE_CHAR, 8'h30, 6'd0, 2'd0));
    // shrink the hold below the ticks already spent: it ends on the next tick
    rows.push_back(cfg_row(CFG_LONG_WAIT, 16'd1));
    rows.push_back(tick_row(MODE_CHAR, 8'h7E, 6'd0, 2'd0));
    rows.push_back(tick_row(MODE_IDLE, 8'h00, 6'd0, 2'd0));
    rows.push_back(cfg_row(CFG_SHORT_WAIT, 16'd0));
    rows.push_back(tick_row(MODE_IDLE, 8'h00, 6'd0, 2'd0));

    // hold reset, then release it on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_gap_pct   = 20;
    recv_stall_pct = 20;
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_drained();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_tick(rows[i].tick, rows[i].fixed, rows[i].want);
      end
    end

    // Random part: drain, reload every register, change the idle profile, advance.
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_drained();
      pick = timing_sets[(p + p / 4) % 4];
      write_reg(CFG_POWER_ON_WAIT, pick.power_on_wait);
      write_reg(CFG_SETUP_WAIT, pick.setup_wait);
      write_reg(CFG_PULSE_WIDTH, {8'($urandom), pick.pulse_width});
      write_reg(CFG_SHORT_WAIT, pick.short_wait);
      write_reg(CFG_LONG_WAIT, pick.long_wait);
      write_reg(CFG_CLEAR_EXTRA_WAIT, pick.clear_extra_wait);
      send_gap_pct   = send_pct[p % 4];
      recv_stall_pct = stall_pct[p % 4];
      repeat (TICKS_PER_PHASE) send_tick(random_tick(), 1'b0, no_check);
    end

    // drain, then let stray results show up before the verdict
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** char_lcd_parallel_writer_top: PASSED **");
    end else begin
      $display("** char_lcd_parallel_writer_top: FAILED **");
    end
    $finish;
  end

endmodule
